### rtl/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// Types and codes shared by the field position command parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpc_pkg;

  localparam int INDEX_BITS_DEFAULT = 16;

  localparam logic [3:0] KIND_SEND = 4'h0;
  localparam logic [3:0] KIND_SKIP = 4'h1;

  localparam logic [3:0] LEN_NONE = 4'd0;
  localparam logic [3:0] LEN_BYTE = 4'd1;
  localparam logic [3:0] LEN_HALF = 4'd2;
  localparam logic [3:0] LEN_WORD = 4'd4;

  localparam logic [2:0] ST_OK              = 3'd0;
  localparam logic [2:0] ST_BAD_LENGTH      = 3'd1;
  localparam logic [2:0] ST_BAD_KIND        = 3'd2;
  localparam logic [2:0] ST_SEND_NOT_ONE    = 3'd3;
  localparam logic [2:0] ST_TOO_MANY_LEVELS = 3'd4;
  localparam logic [2:0] ST_TRUNCATED       = 3'd5;

  localparam logic [1:0] LEVEL_TOP = 2'd0;
  localparam logic [1:0] LEVEL_SUB = 2'd1;
  localparam logic [1:0] LEVEL_MAX = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } request_t;

  typedef struct packed {
    logic [15:0] field_index;
    logic [15:0] subfield_index;
    logic [2:0]  status;
  } result_t;

endpackage

`default_nettype wire

### rtl/field_position_command_parser.sv
// ----------------------------------------------------------------------------
// field_position_command_parser
// Parses a request frame of header/parameter commands one byte at a time
// and reports the field and sub-field positions with a status per frame.
// ----------------------------------------------------------------------------
// Takes one request byte per cycle. A result appears in the result register in
// the cycle after the byte marked frame_last is accepted; the parser state is
// cleared in the same cycle, so the first byte of the next frame may follow
// at once. The request side stalls only while a finished result is held and
// its own consumer stalls. Indices are INDEX_BITS wide and reported in their
// low 16 bits.
`timescale 1ns / 1ps
`default_nettype none

module field_position_command_parser #(
  parameter int INDEX_BITS = fpc_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             request_valid,
  output logic                  request_stall,
  input  wire fpc_pkg::request_t request,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output fpc_pkg::result_t      result
);

  import fpc_pkg::*;

  logic [2:0]            bytes_left,      bytes_left_next;
  logic [3:0]            command_kind,    command_kind_next;
  logic [31:0]           parameter_value, parameter_value_next;
  logic [1:0]            byte_shift,      byte_shift_next;
  logic [1:0]            level,           level_next;
  logic [INDEX_BITS-1:0] field_acc,       field_acc_next;
  logic [INDEX_BITS-1:0] subfield_acc,    subfield_acc_next;
  logic [2:0]            error_code,      error_code_next;

  logic                  req_acc;
  logic                  exec_en;
  logic [3:0]            exec_kind;
  logic [31:0]           exec_value;
  logic [3:0]            hdr_len;
  logic [2:0]            final_status;
  logic [31:0]           field_wide;
  logic [31:0]           subfield_wide;

  assign request_stall = result_valid && result_stall;
  assign req_acc       = request_valid && !request_stall;
  assign hdr_len       = request.data_byte[3:0];

  always_comb begin
    bytes_left_next      = bytes_left;
    command_kind_next    = command_kind;
    parameter_value_next = parameter_value;
    byte_shift_next      = byte_shift;
    level_next           = level;
    field_acc_next       = field_acc;
    subfield_acc_next    = subfield_acc;
    error_code_next      = error_code;
    exec_en              = 1'b0;
    exec_kind            = command_kind;
    exec_value           = parameter_value;

    if (error_code == ST_OK) begin
      if (bytes_left == 3'd0) begin
        command_kind_next    = request.data_byte[7:4];
        parameter_value_next = '0;
        byte_shift_next      = '0;
        exec_kind            = request.data_byte[7:4];
        exec_value           = '0;
        if (!(hdr_len inside {LEN_NONE, LEN_BYTE, LEN_HALF, LEN_WORD})) begin
          error_code_next = ST_BAD_LENGTH;
        end else if (hdr_len == LEN_NONE) begin
          exec_en = 1'b1;
        end else begin
          bytes_left_next = hdr_len[2:0];
        end
      end else begin
        parameter_value_next = parameter_value
                             | (32'(request.data_byte) << {byte_shift, 3'b000});
        byte_shift_next      = byte_shift + 2'd1;
        bytes_left_next      = bytes_left - 3'd1;
        exec_value           = parameter_value_next;
        exec_en              = (bytes_left == 3'd1);
      end
    end

    if (exec_en) begin
      case (exec_kind)
        KIND_SKIP: begin
          if (level == LEVEL_TOP) begin
            field_acc_next = field_acc + exec_value[INDEX_BITS-1:0];
          end else if (level == LEVEL_SUB) begin
            subfield_acc_next = subfield_acc + exec_value[INDEX_BITS-1:0];
          end
        end
        KIND_SEND: begin
          if (exec_value != 32'd1) begin
            error_code_next = ST_SEND_NOT_ONE;
          end else if (level >= LEVEL_MAX) begin
            error_code_next = ST_TOO_MANY_LEVELS;
          end else begin
            level_next = level + 2'd1;
          end
        end
        default: begin
          error_code_next = ST_BAD_KIND;
        end
      endcase
    end

    final_status = error_code_next;
    if (error_code_next == ST_OK && bytes_left_next != 3'd0) begin
      final_status = ST_TRUNCATED;
    end
  end

  assign field_wide    = 32'(field_acc_next);
  assign subfield_wide = 32'(subfield_acc_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left      <= '0;
      command_kind    <= '0;
      parameter_value <= '0;
      byte_shift      <= '0;
      level           <= '0;
      field_acc       <= '0;
      subfield_acc    <= '0;
      error_code      <= ST_OK;
      result_valid    <= 1'b0;
    end else begin
      if (!request_stall) begin
        result_valid <= 1'b0;
      end
      if (req_acc) begin
        if (request.frame_last) begin
          bytes_left      <= '0;
          command_kind    <= '0;
          parameter_value <= '0;
          byte_shift      <= '0;
          level           <= '0;
          field_acc       <= '0;
          subfield_acc    <= '0;
          error_code      <= ST_OK;
          result_valid    <= 1'b1;
        end else begin
          bytes_left      <= bytes_left_next;
          command_kind    <= command_kind_next;
          parameter_value <= parameter_value_next;
          byte_shift      <= byte_shift_next;
          level           <= level_next;
          field_acc       <= field_acc_next;
          subfield_acc    <= subfield_acc_next;
          error_code      <= error_code_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc && request.frame_last) begin
      result.field_index    <= field_wide[15:0];
      result.subfield_index <= subfield_wide[15:0];
      result.status         <= final_status;
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    req_acc && request.frame_last |=> result_valid)
    else $error("frame end did not produce a result");

  a_error_sticks: assert property (@(posedge clk) disable iff (rst)
    req_acc && !request.frame_last && error_code != ST_OK
      |=> error_code == $past(error_code))
    else $error("held error changed within a frame");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_MAX && bytes_left <= 3'd4)
    else $error("level or byte count out of range");

  a_stalled_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> !req_acc)
    else $error("request taken while result stalled");

endmodule

`default_nettype wire
